// ----- hw/rtl/tpfc_pkg.sv -----
`timescale 1ns / 1ps
package tpfc_pkg;

    // Angle unit: degrees scaled by 2^22.
    localparam int AU_FRAC  = 22;
    localparam int LEN_FRAC = 8;
    localparam int TAB_LEN  = 24;

    // Reciprocal of the CORDIC gain, scaled by 2^30.
    localparam logic [29:0] INVK = 30'd652032874;

    localparam logic signed [33:0] DEG90  = 34'sd377487360;
    localparam logic signed [33:0] DEG180 = 34'sd754974720;
    localparam logic signed [33:0] DEG360 = 34'sd1509949440;

    // Arctangent table, one entry per CORDIC stage, in the angle unit.
    function automatic logic signed [33:0] arctan_au(input int idx);
        logic signed [33:0] r;
        begin
            case (idx)
                0:  r = 34'sd188743680;
                1:  r = 34'sd111421900;
                2:  r = 34'sd58872272;
                3:  r = 34'sd29884485;
                4:  r = 34'sd15000234;
                5:  r = 34'sd7507429;
                6:  r = 34'sd3754631;
                7:  r = 34'sd1877430;
                8:  r = 34'sd938729;
                9:  r = 34'sd469366;
                10: r = 34'sd234683;
                11: r = 34'sd117342;
                12: r = 34'sd58671;
                13: r = 34'sd29335;
                14: r = 34'sd14668;
                15: r = 34'sd7334;
                16: r = 34'sd3667;
                17: r = 34'sd1833;
                18: r = 34'sd917;
                19: r = 34'sd458;
                20: r = 34'sd229;
                21: r = 34'sd115;
                22: r = 34'sd57;
                23: r = 34'sd29;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    // Base-36 digit value of one code byte; anything else counts as zero.
    function automatic logic [5:0] digit36(input logic [7:0] ch);
        logic [5:0] r;
        begin
            if (ch >= 8'h30 && ch <= 8'h39)
                r = 6'(ch - 8'h30);
            else if (ch >= 8'h41 && ch <= 8'h5A)
                r = 6'(ch - 8'h41 + 8'd10);
            else
                r = 6'd0;
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/teammate_position_from_code.sv -----
`timescale 1ns / 1ps
// A beat passes stages A, B, rotation CORDIC, C, vectoring CORDIC, D and output.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// stage is free or being emptied, so a stall freezes every stage in place.
// Both rotation CORDICs run side by side, then a vectoring CORDIC of the same depth.
// Reset clears all valid bits; data registers are not reset.
module teammate_position_from_code #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] own_bearing,
    input  logic [22:0] own_distance,
    input  logic [7:0]  code_char0,
    input  logic [7:0]  code_char1,
    input  logic [7:0]  code_char2,
    input  logic [7:0]  code_char3,
    input  logic [7:0]  code_char4,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mate_bearing,
    output logic [23:0] mate_distance
);
    import tpfc_pkg::*;

    localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int AB = AU_FRAC - ANGLE_FRAC_BITS;
    localparam logic [19:0] FULL = 20'(360 << ANGLE_FRAC_BITS);
    // Whole turns that a 16-bit bearing can hold beyond the first.
    localparam int NRED = 65535 / (360 << ANGLE_FRAC_BITS);
    // Lengths in meters * 2^8 fit comfortably in 40 bits with CORDIC growth.
    localparam int LW = 40;

    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Stage A: decode the code, reduce own bearing, form angles.
    logic              a_v_reg;
    logic [33:0]       a_own_ang_reg;
    logic [33:0]       a_mate_ang_reg;
    logic [22:0]       a_od_reg;
    logic [22:0]       a_md_reg;
    logic [10:0]       bv;
    logic [15:0]       dv;
    logic [19:0]       ob;
    logic [15:0]       obm;
    logic [13:0]       mq_num;
    logic [27:0]       mq_prod;

    always_comb
    begin
        bv = 11'd0;
        if (code_char0 != 8'd0)
        begin
            bv = 11'(digit36(code_char0));
            if (code_char1 != 8'd0)
                bv = 11'(bv * 11'd36 + 11'(digit36(code_char1)));
        end
        dv = 16'd0;
        if (code_char2 != 8'd0)
        begin
            dv = 16'(digit36(code_char2));
            if (code_char3 != 8'd0)
            begin
                dv = 16'(dv * 16'd36 + 16'(digit36(code_char3)));
                if (code_char4 != 8'd0)
                    dv = 16'(dv * 16'd36 + 16'(digit36(code_char4)));
            end
        end
        // One compare and subtract for each whole turn a 16-bit bearing can exceed.
        ob = {4'd0, own_bearing};
        for (int k = 0; k < NRED; k++)
            if (ob >= FULL)
                ob = ob - FULL;
        obm = ob[15:0];
        // v*5*2^22/18 splits into v*1165084 plus (8v + 9)/18; the small quotient
        // comes from a multiply by 2^18/18 rounded up, exact below 2^15.
        mq_num  = {bv, 3'b000} + 14'd9;
        mq_prod = 28'(mq_num) * 28'd14564;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_own_ang_reg  <= 34'({18'd0, obm} << AB);
            a_mate_ang_reg <= 34'(bv) * 34'd1165084 + 34'(mq_prod[27:18]);
            a_od_reg       <= own_distance;
            a_md_reg       <= 23'({7'd0, dv} * 23'd100);
        end
    end

    // Stage B: gain compensation and quadrant pre-rotation.
    logic                 b_v_reg;
    logic signed [LW-1:0] ox_reg, oy_reg, mx_reg, my_reg;
    logic signed [33:0]   oz_reg, mz_reg;

    function automatic void prerot(input logic [22:0] d, input logic [33:0] a,
                                   output logic signed [LW-1:0] x,
                                   output logic signed [LW-1:0] y,
                                   output logic signed [33:0] z);
        logic [52:0]          p;
        logic signed [LW-1:0] m;
        logic signed [34:0]   ang;
        begin
            p   = {30'd0, d} * {23'd0, INVK};
            m   = LW'(p >> (30 - LEN_FRAC));
            ang = 35'($signed({1'b0, a}));
            if (ang > 35'(DEG180))
                ang = ang - 35'(DEG360);
            if (ang > 35'(DEG90))
            begin
                x = '0; y = m; z = 34'(ang - 35'(DEG90));
            end
            else if (ang < -35'(DEG90))
            begin
                x = '0; y = -m; z = 34'(ang + 35'(DEG90));
            end
            else
            begin
                x = m; y = '0; z = 34'(ang);
            end
        end
    endfunction

    logic signed [LW-1:0] pox, poy, pmx, pmy;
    logic signed [33:0]   poz, pmz;

    always_comb
    begin
        prerot(a_od_reg, a_own_ang_reg, pox, poy, poz);
        prerot(a_md_reg, a_mate_ang_reg, pmx, pmy, pmz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (adv)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= pox; oy_reg <= poy; oz_reg <= poz;
            mx_reg <= pmx; my_reg <= pmy; mz_reg <= pmz;
        end
    end

    // Rotation CORDIC pipelines for both vectors, one stage per iteration.
    logic                 r_v_reg  [NS];
    logic signed [LW-1:0] rox_reg  [NS];
    logic signed [LW-1:0] roy_reg  [NS];
    logic signed [33:0]   roz_reg  [NS];
    logic signed [LW-1:0] rmx_reg  [NS];
    logic signed [LW-1:0] rmy_reg  [NS];
    logic signed [33:0]   rmz_reg  [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        logic                 vin;
        logic signed [LW-1:0] xo, yo, xm, ym;
        logic signed [33:0]   zo, zm;
        if (i == 0)
        begin : g_first
            assign vin = b_v_reg;
            assign xo = ox_reg; assign yo = oy_reg; assign zo = oz_reg;
            assign xm = mx_reg; assign ym = my_reg; assign zm = mz_reg;
        end
        else
        begin : g_next
            assign vin = r_v_reg[i-1];
            assign xo = rox_reg[i-1]; assign yo = roy_reg[i-1]; assign zo = roz_reg[i-1];
            assign xm = rmx_reg[i-1]; assign ym = rmy_reg[i-1]; assign zm = rmz_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                r_v_reg[i] <= 1'b0;
            else if (adv)
                r_v_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (zo >= 0)
                begin
                    rox_reg[i] <= xo - (yo >>> i);
                    roy_reg[i] <= yo + (xo >>> i);
                    roz_reg[i] <= zo - arctan_au(i);
                end
                else
                begin
                    rox_reg[i] <= xo + (yo >>> i);
                    roy_reg[i] <= yo - (xo >>> i);
                    roz_reg[i] <= zo + arctan_au(i);
                end
                if (zm >= 0)
                begin
                    rmx_reg[i] <= xm - (ym >>> i);
                    rmy_reg[i] <= ym + (xm >>> i);
                    rmz_reg[i] <= zm - arctan_au(i);
                end
                else
                begin
                    rmx_reg[i] <= xm + (ym >>> i);
                    rmy_reg[i] <= ym - (xm >>> i);
                    rmz_reg[i] <= zm + arctan_au(i);
                end
            end
        end
    end

    // Stage C: difference vector, half-plane fold and zero detect.
    logic                 c_v_reg;
    logic                 c_zero_reg;
    logic signed [LW:0]   c_x_reg, c_y_reg;
    logic signed [34:0]   c_z_reg;
    logic signed [LW:0]   dx, dy;

    always_comb
    begin
        dx = (LW+1)'(rox_reg[NS-1]) - (LW+1)'(rmx_reg[NS-1]);
        dy = (LW+1)'(roy_reg[NS-1]) - (LW+1)'(rmy_reg[NS-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (adv)
            c_v_reg <= r_v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_zero_reg <= (dx == 0) && (dy == 0);
            if (dx < 0)
            begin
                c_x_reg <= -dx; c_y_reg <= -dy; c_z_reg <= 35'(DEG180);
            end
            else
            begin
                c_x_reg <= dx; c_y_reg <= dy; c_z_reg <= '0;
            end
        end
    end

    // Vectoring CORDIC pipeline.
    logic                 v_v_reg  [NS];
    logic                 v_zr_reg [NS];
    logic signed [LW:0]   vx_reg   [NS];
    logic signed [LW:0]   vy_reg   [NS];
    logic signed [34:0]   vz_reg   [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_vec
        logic               vin, zin;
        logic signed [LW:0] xi, yi;
        logic signed [34:0] zi;
        if (i == 0)
        begin : g_first
            assign vin = c_v_reg; assign zin = c_zero_reg;
            assign xi = c_x_reg; assign yi = c_y_reg; assign zi = c_z_reg;
        end
        else
        begin : g_next
            assign vin = v_v_reg[i-1]; assign zin = v_zr_reg[i-1];
            assign xi = vx_reg[i-1]; assign yi = vy_reg[i-1]; assign zi = vz_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_v_reg[i] <= 1'b0;
            else if (adv)
                v_v_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_zr_reg[i] <= zin;
                if (yi >= 0)
                begin
                    vx_reg[i] <= xi + (yi >>> i);
                    vy_reg[i] <= yi - (xi >>> i);
                    vz_reg[i] <= zi + 35'(arctan_au(i));
                end
                else
                begin
                    vx_reg[i] <= xi - (yi >>> i);
                    vy_reg[i] <= yi + (xi >>> i);
                    vz_reg[i] <= zi - 35'(arctan_au(i));
                end
            end
        end
    end

    // Stage D: wrap and round the bearing, gain-correct the length.
    logic               d_v_reg, d_zr_reg;
    logic [15:0]        d_bear_reg;
    logic [LW+30:0]     d_prod_reg;
    logic signed [34:0] zw;
    logic [33:0]        brnd;
    logic [LW-1:0]      xpos;

    always_comb
    begin
        zw = vz_reg[NS-1];
        if (zw < 0)
            zw = zw + 35'(DEG360);
        if (zw >= 35'(DEG360))
            zw = zw - 35'(DEG360);
        brnd = 34'((34'(zw) + (34'd1 << (AB - 1))) >> AB);
        xpos = (vx_reg[NS-1] < 0) ? '0 : vx_reg[NS-1][LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (adv)
            d_v_reg <= v_v_reg[NS-1];
    end

    // The vector length stays below 2^34 for the widest inputs, so only those bits
    // enter the gain multiplier.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_zr_reg   <= v_zr_reg[NS-1];
            d_bear_reg <= (brnd >= 34'(FULL)) ? 16'd0 : brnd[15:0];
            d_prod_reg <= (LW+31)'(xpos[33:0]) * (LW+31)'(INVK);
        end
    end

    // Output register.
    logic        out_v_reg;
    logic [15:0] ob_reg;
    logic [23:0] od_reg;
    logic [LW:0] dsc;

    always_comb
        dsc = (LW+1)'(((d_prod_reg >> 30) + (LW+31)'(1 << (LEN_FRAC - 1))) >> LEN_FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d_zr_reg)
            begin
                ob_reg <= 16'(90 << ANGLE_FRAC_BITS);
                od_reg <= 24'd0;
            end
            else
            begin
                ob_reg <= d_bear_reg;
                od_reg <= (dsc > (LW+1)'(24'hFFFFFF)) ? 24'hFFFFFF : dsc[23:0];
            end
        end
    end

    assign out_valid     = out_v_reg;
    assign mate_bearing  = ob_reg;
    assign mate_distance = od_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import tpfc_pkg::*;

    localparam int STAGES = 16;
    localparam int AFRAC = 7;
    localparam longint unsigned FULL_TURN = 64'd360 << AFRAC;
    localparam int LATENCY = 2 * STAGES + 5;

    // Arctangent steps in degrees scaled by 2^22.
    localparam longint ATAN_STEP [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] own_bearing = '0;
    logic [22:0] own_distance = '0;
    logic [7:0] code_char0 = '0;
    logic [7:0] code_char1 = '0;
    logic [7:0] code_char2 = '0;
    logic [7:0] code_char3 = '0;
    logic [7:0] code_char4 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] mate_bearing;
    logic [23:0] mate_distance;

    logic [15:0] bearing_due [$];
    logic [23:0] distance_due [$];
    bit failed = 0;
    int stall_pct = 0;
    int hold_req_seq = 0;
    int hold_seen_seq = 0;
    int hold_left = 0;

    teammate_position_from_code dut (.*);

    always #5 clk = ~clk;

    // Base-36 digit of one code byte; other bytes count as zero.
    function automatic longint unsigned code_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return ch - "0";
        if (ch >= "A" && ch <= "Z")
            return ch - "A" + 10;
        return 0;
    endfunction

    // Turns a length and compass angle into north and east components.
    function automatic void polar_to_ne(input longint unsigned len, input longint ang_in,
                                        output longint north, output longint east);
        longint m, x, y, z, nx, ny;
        m = longint'((len * longint'(INVK)) >> 22);
        z = ang_in;
        if (z > longint'(DEG180))
            z -= longint'(DEG360);
        if (z > longint'(DEG90)) begin
            x = 0; y = m; z -= longint'(DEG90);
        end else if (z < -longint'(DEG90)) begin
            x = 0; y = -m; z += longint'(DEG90);
        end else begin
            x = m; y = 0;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_STEP[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_STEP[i];
            end
            x = nx; y = ny;
        end
        north = x;
        east = y;
    endfunction

    // Works out the bearing and distance to the teammate for one beat.
    function automatic void locate_mate(input logic [15:0] ob, input logic [22:0] od,
                                        input logic [7:0] ch [5],
                                        output logic [15:0] bear_o,
                                        output logic [23:0] dist_o);
        longint unsigned bv, dv, bear, span;
        longint oc, os, mc, ms, px, py, z, nx, ny;
        bv = 0;
        dv = 0;
        for (int k = 0; k < 2; k++) begin
            if (ch[k] == 8'h00)
                break;
            bv = bv * 36 + code_digit(ch[k]);
        end
        for (int k = 2; k < 5; k++) begin
            if (ch[k] == 8'h00)
                break;
            dv = dv * 36 + code_digit(ch[k]);
        end
        polar_to_ne(od, longint'((ob % FULL_TURN) << (22 - AFRAC)), oc, os);
        polar_to_ne(dv * 100, longint'((bv * 5 * (64'd1 << 22) + 9) / 18), mc, ms);
        px = oc - mc;
        py = os - ms;
        if (px == 0 && py == 0) begin
            bear = 64'd90 << AFRAC;
            span = 0;
        end else begin
            z = 0;
            if (px < 0) begin
                px = -px; py = -py; z = longint'(DEG180);
            end
            for (int i = 0; i < STAGES && i < 24; i++) begin
                if (py >= 0) begin
                    nx = px + (py >>> i); ny = py - (px >>> i); z += ATAN_STEP[i];
                end else begin
                    nx = px - (py >>> i); ny = py + (px >>> i); z -= ATAN_STEP[i];
                end
                px = nx; py = ny;
            end
            if (z < 0)
                z += longint'(DEG360);
            if (z >= longint'(DEG360))
                z -= longint'(DEG360);
            bear = (longint'(z) + (64'd1 << (21 - AFRAC))) >> (22 - AFRAC);
            if (bear >= FULL_TURN)
                bear = 0;
            if (px < 0)
                px = 0;
            span = (longint'(px) * longint'(INVK)) >> 30;
            span = (span + 128) >> 8;
            if (span > 64'hFFFFFF)
                span = 64'hFFFFFF;
        end
        bear_o = bear[15:0];
        dist_o = span[23:0];
    endfunction

    // Offers one beat and waits until it is taken; valid is left high.
    task automatic send_beat(input logic [15:0] ob, input logic [22:0] od,
                             input logic [7:0] ch [5]);
        logic [15:0] b;
        logic [23:0] d;
        own_bearing <= ob;
        own_distance <= od;
        code_char0 <= ch[0];
        code_char1 <= ch[1];
        code_char2 <= ch[2];
        code_char3 <= ch[3];
        code_char4 <= ch[4];
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        locate_mate(ob, od, ch, b, d);
        bearing_due.push_back(b);
        distance_due.push_back(d);
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (bearing_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                return "0" + 8'($urandom_range(0, 9));
            5, 6:
                return "A" + 8'($urandom_range(0, 25));
            7:
                return 8'h00;
            default:
                return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count, input int gap_pct);
        logic [7:0] ch [5];
        logic [15:0] ob;
        for (int n = 0; n < count; n++) begin
            foreach (ch[k])
                ch[k] = random_char();
            ob = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46079));
            send_beat(ob, 23'($urandom), ch);
            if ($urandom_range(0, 99) < gap_pct)
                idle_for($urandom_range(1, 6));
        end
    endtask

    // Extremes of every field, the NUL rules and the zero difference vector.
    task automatic test_directed();
        send_beat(16'd0, 23'd0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_beat(16'd0, 23'd100, '{"0", "0", "0", "0", "1"});
        send_beat(16'd46079, 23'h7FFFFF, '{"Z", "Z", "Z", "Z", "Z"});
        send_beat(16'hFFFF, 23'h7FFFFF, '{"0", "0", "0", "0", "0"});
        send_beat(16'd46080, 23'd5000, '{"9", "A", "1", "2", "3"});
        send_beat(16'd0, 23'd500, '{"0", "0", "0", "0", "1"});
        send_beat(16'd23040, 23'd500, '{"0", "0", "0", "0", "1"});
        send_beat(16'd23040, 23'd100, '{"I", "0", "0", "0", "1"});
        send_beat(16'd11520, 23'd0, '{"9", "0", "0", "0", "5"});
        send_beat(16'd34560, 23'd0, '{"R", "0", "0", "0", "5"});
        send_beat(16'd1000, 23'd77777, '{"Z", 8'h00, "5", 8'h00, "Z"});
        send_beat(16'd1000, 23'd77777, '{8'h00, "Z", 8'h00, "5", "5"});
        send_beat(16'd200, 23'd4242, '{"a", 8'hFF, "z", 8'h80, "!"});
        send_beat(16'd46079, 23'd12345, '{"1", "2", "Z", "Z", 8'h00});
        send_beat(16'd12345, 23'h555555, '{8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h01});
        send_beat(16'h8000, 23'h400000, '{"Z", "Z", "0", "0", "0"});
        idle_for(3);
    endtask

    task automatic test_flowing();
        stall_pct = 0;
        send_random(150, 0);
        stall_pct = 30;
        send_random(300, 25);
        stall_pct = 70;
        send_random(250, 40);
    endtask

    // The receiver holds off while beats keep coming, so the pipeline backs up.
    task automatic test_backpressure();
        stall_pct = 20;
        hold_req_seq++;
        send_random(150, 0);
    endtask

    task automatic test_pause_until_drained();
        stall_pct = 40;
        send_random(100, 20);
        wait_drained();
        send_random(200, 30);
    endtask

    // Receiver: stalls at random, with an occasional long hold-off.
    always @(posedge clk) begin
        if (hold_seen_seq != hold_req_seq) begin
            hold_seen_seq <= hold_req_seq;
            hold_left <= 200;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker: each result beat is matched against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (bearing_due.size() == 0) begin
                $error("result beat with nothing expected");
                failed = 1;
            end else begin
                if (mate_bearing !== bearing_due[0]) begin
                    $error("mate_bearing expected %0d actual %0d", bearing_due[0],
                           mate_bearing);
                    failed = 1;
                end
                if (mate_distance !== distance_due[0]) begin
                    $error("mate_distance expected %0d actual %0d", distance_due[0],
                           mate_distance);
                    failed = 1;
                end
                void'(bearing_due.pop_front());
                void'(distance_due.pop_front());
            end
        end
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_flowing();
        test_backpressure();
        test_pause_until_drained();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (bearing_due.size() != 0)
            failed = 1;
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tpfc_pkg.sv
hw/rtl/teammate_position_from_code.sv
tb/tb.sv
